@@ hdl/vwd_pkg.sv @@
`timescale 1ns / 1ps
package vwd_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_WIDTH_DEF  = 32;

	// fixed field widths of the channels and registers
	localparam int REQ_W      = 2;
	localparam int COORD_IN_W = 32;
	localparam int IDX_OUT_W  = 10;
	localparam int STATUS_W   = 2;
	localparam int TOL_W      = 31;
	localparam int CFG_IDX_W  = 1;
	localparam int SUM_W      = 64;

	localparam logic [TOL_W-1:0] TOL_RESET  = 31'd66;
	localparam logic             WELD_RESET = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE   = 1'd0,
		REG_WELD_ENABLE = 1'd1
	} cfg_reg_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_VERTEX = 2'd0,
		REQ_REMAP  = 2'd1,
		REQ_CLEAR  = 2'd2
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_UNLOADED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SQ_TOL = 2'd0,
		SQ_DX  = 2'd1,
		SQ_DY  = 2'd2,
		SQ_DZ  = 2'd3
	} sq_sel_t;

	typedef struct packed {
		logic    diff_en;
		logic    mul_en;
		sq_sel_t sel;
		logic    tol_load;
		logic    acc_load;
		logic    acc_add;
	} dist_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_TOL,
		S_TOL_LD,
		S_READ,
		S_DIFF,
		S_MX,
		S_MY,
		S_MZ,
		S_CMP,
		S_APPEND,
		S_MAP_WR,
		S_MAP_RD,
		S_MAP_DATA,
		S_DONE
	} state_t;

endpackage

@@ hdl/vwd_req_if.sv @@
`timescale 1ns / 1ps
interface vwd_req_if import vwd_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic        [REQ_W-1:0]      req_type;
	logic signed [COORD_IN_W-1:0] pos_x;
	logic signed [COORD_IN_W-1:0] pos_y;
	logic signed [COORD_IN_W-1:0] pos_z;
	logic        [IDX_OUT_W-1:0]  old_index;

	modport source (output valid, req_type, pos_x, pos_y, pos_z, old_index, input ready);
	modport sink (input valid, req_type, pos_x, pos_y, pos_z, old_index, output ready);
endinterface

@@ hdl/vwd_res_if.sv @@
`timescale 1ns / 1ps
interface vwd_res_if import vwd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] new_index;
	logic                 is_new;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, new_index, is_new, status, input ready);
	modport sink (input valid, new_index, is_new, status, output ready);
endinterface

@@ hdl/vertex_weld_dedup_top.sv @@
`timescale 1ns / 1ps
// vertex with welding on: S_TOL and S_TOL_LD, then per kept slot a read, a diff, three multiplier
// passes and a compare until one matches; a match goes on to S_MAP_WR, no match through S_APPEND;
// welded remap of a loaded index reads the map, pass-through vertex writes it, others go to S_DONE
// one transaction in flight: the next is taken the cycle after the result enters the free
// output register
// reset: counters clear, tolerance 66, welding on; memory read data is only used below their counts
module vertex_weld_dedup_top import vwd_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	vwd_req_if.sink              req,
	vwd_res_if.source            res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TOL_W-1:0]     cfg_data
);
	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;

	state_t state_q, state_d;

	logic [TOL_W-1:0] tolerance_q;
	logic             weld_q;
	logic [CNT_W-1:0] kept_count_q;
	logic [CNT_W-1:0] loaded_count_q;

	logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;
	logic [IDX_OUT_W-1:0] old_q;
	logic [IDX_W-1:0]     slot_q;
	logic [IDX_W-1:0]     map_val_q;
	logic [IDX_OUT_W-1:0] res_idx_q;
	logic                 res_new_q;
	status_t              res_status_q;

	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic                 out_new_q;
	status_t              out_status_q;

	dist_ctl_t ctl;
	logic      dist_hit;
	logic      req_fire;
	logic      out_load;
	logic      store_full;
	logic      req_loaded;
	logic      slot_last;
	logic [CNT_W-1:0] slot_next_cnt;
	logic [CMP_W-1:0] old_ext;

	logic [IDX_OUT_W-1:0] start_idx;
	status_t              start_status;

	logic [3*COORD_WIDTH-1:0] kept_rdata;
	logic [IDX_W-1:0]         map_rdata;

	assign req.ready     = (state_q == S_IDLE);
	assign req_fire      = req.valid && req.ready;
	assign store_full    = (loaded_count_q == CNT_W'(MAX_VERTICES));
	assign req_loaded    = CMP_W'(req.old_index) < CMP_W'(loaded_count_q);
	assign slot_next_cnt = CNT_W'(slot_q) + CNT_W'(1);
	assign slot_last     = (slot_next_cnt == kept_count_q);
	assign old_ext       = CMP_W'(old_q);
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || res.ready);

	vwd_ram #(
		.WIDTH (3 * COORD_WIDTH),
		.DEPTH (MAX_VERTICES)
	) u_kept_ram (
		.clk   (clk),
		.we    (state_q == S_APPEND),
		.waddr (kept_count_q[IDX_W-1:0]),
		.wdata ({px_q, py_q, pz_q}),
		.raddr (slot_q),
		.rdata (kept_rdata)
	);

	vwd_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_VERTICES)
	) u_map_ram (
		.clk   (clk),
		.we    (state_q == S_MAP_WR),
		.waddr (loaded_count_q[IDX_W-1:0]),
		.wdata (map_val_q),
		.raddr (old_ext[IDX_W-1:0]),
		.rdata (map_rdata)
	);

	vwd_dist_unit #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dist (
		.clk       (clk),
		.ctl       (ctl),
		.tolerance (tolerance_q),
		.px        (px_q),
		.py        (py_q),
		.pz        (pz_q),
		.kept      (kept_rdata),
		.hit       (dist_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req_type_t'(req.req_type))
						REQ_VERTEX: begin
							if (store_full) begin
								state_d = S_DONE;
							end else if (!weld_q) begin
								state_d = S_MAP_WR;
							end else begin
								state_d = S_TOL;
							end
						end
						REQ_REMAP: state_d = (weld_q && req_loaded) ? S_MAP_RD : S_DONE;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_TOL: begin
				ctl.mul_en = 1'b1;
				ctl.sel    = SQ_TOL;
				state_d    = S_TOL_LD;
			end
			S_TOL_LD: begin
				ctl.tol_load = 1'b1;
				state_d      = (kept_count_q == '0) ? S_APPEND : S_READ;
			end
			S_READ: state_d = S_DIFF;
			S_DIFF: begin
				ctl.diff_en = 1'b1;
				state_d     = S_MX;
			end
			S_MX: begin
				ctl.mul_en = 1'b1;
				ctl.sel    = SQ_DX;
				state_d    = S_MY;
			end
			S_MY: begin
				ctl.mul_en   = 1'b1;
				ctl.sel      = SQ_DY;
				ctl.acc_load = 1'b1;
				state_d      = S_MZ;
			end
			S_MZ: begin
				ctl.mul_en  = 1'b1;
				ctl.sel     = SQ_DZ;
				ctl.acc_add = 1'b1;
				state_d     = S_CMP;
			end
			S_CMP: begin
				priority if (dist_hit) begin
					state_d = S_MAP_WR;
				end else if (slot_last) begin
					state_d = S_APPEND;
				end else begin
					state_d = S_READ;
				end
			end
			S_APPEND:   state_d = S_MAP_WR;
			S_MAP_WR:   state_d = S_DONE;
			S_MAP_RD:   state_d = S_MAP_DATA;
			S_MAP_DATA: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result fields already known when the transaction is taken
	always_comb begin
		start_idx    = '0;
		start_status = STATUS_OK;
		unique case (req_type_t'(req.req_type))
			REQ_VERTEX: begin
				if (store_full) begin
					start_status = STATUS_FULL;
				end else if (!weld_q) begin
					start_idx = IDX_OUT_W'(loaded_count_q);
				end
			end
			REQ_REMAP: begin
				if (!req_loaded) begin
					start_status = STATUS_UNLOADED;
				end
				if (!weld_q) begin
					start_idx = req.old_index;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q    <= TOL_RESET;
			weld_q         <= WELD_RESET;
			kept_count_q   <= '0;
			loaded_count_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_TOLERANCE:   tolerance_q <= cfg_data;
					REG_WELD_ENABLE: weld_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (req_fire && req_type_t'(req.req_type) == REQ_CLEAR) begin
				kept_count_q   <= '0;
				loaded_count_q <= '0;
			end
			if (state_q == S_APPEND) begin
				kept_count_q <= kept_count_q + CNT_W'(1);
			end
			if (state_q == S_MAP_WR) begin
				loaded_count_q <= loaded_count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			px_q         <= req.pos_x[COORD_WIDTH-1:0];
			py_q         <= req.pos_y[COORD_WIDTH-1:0];
			pz_q         <= req.pos_z[COORD_WIDTH-1:0];
			old_q        <= req.old_index;
			slot_q       <= '0;
			map_val_q    <= loaded_count_q[IDX_W-1:0];
			res_idx_q    <= start_idx;
			res_new_q    <= 1'b0;
			res_status_q <= start_status;
		end
		if (state_q == S_CMP) begin
			if (dist_hit) begin
				res_idx_q <= IDX_OUT_W'(slot_q);
				map_val_q <= slot_q;
			end else begin
				slot_q <= slot_q + IDX_W'(1);
			end
		end
		if (state_q == S_APPEND) begin
			res_idx_q <= IDX_OUT_W'(kept_count_q);
			map_val_q <= kept_count_q[IDX_W-1:0];
			res_new_q <= 1'b1;
		end
		if (state_q == S_MAP_DATA) begin
			res_idx_q <= IDX_OUT_W'(map_rdata);
		end
		if (out_load) begin
			out_idx_q    <= res_idx_q;
			out_new_q    <= res_new_q;
			out_status_q <= res_status_q;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.new_index = out_idx_q;
	assign res.is_new    = out_new_q;
	assign res.status    = out_status_q;

	// every kept slot came from some loaded vertex; the map write directly follows the append
	a_kept_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_MAP_WR |-> kept_count_q <= loaded_count_q)
		else $error("kept count exceeds loaded count");

	a_loaded_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_count_q <= CNT_W'(MAX_VERTICES))
		else $error("loaded count beyond store depth");

	// kept count only steps by one or clears
	a_kept_step: assert property (@(posedge clk) disable iff (!arst_n)
		kept_count_q != $past(kept_count_q) |->
			(kept_count_q == $past(kept_count_q) + CNT_W'(1)) || (kept_count_q == '0))
		else $error("kept count jumped");

	a_new_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_new |-> res.status == STATUS_OK)
		else $error("appended vertex reported with bad status");
endmodule

@@ hdl/vwd_ram.sv @@
`timescale 1ns / 1ps
module vwd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ hdl/vwd_dist_unit.sv @@
`timescale 1ns / 1ps
module vwd_dist_unit import vwd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  dist_ctl_t                     ctl,
	input  logic        [TOL_W-1:0]       tolerance,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] pz,
	input  logic        [3*COORD_WIDTH-1:0] kept,
	output logic                          hit
);
	localparam int MUL_W  = (COORD_WIDTH > TOL_W) ? COORD_WIDTH : TOL_W;
	localparam int PROD_W = 2 * MUL_W;

	function automatic logic [COORD_WIDTH-1:0] abs_diff(
		input logic signed [COORD_WIDTH-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b
	);
		logic signed [COORD_WIDTH:0] d;
		d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
		if (d[COORD_WIDTH]) begin
			d = -d;
		end
		return d[COORD_WIDTH-1:0];
	endfunction

	logic signed [COORD_WIDTH-1:0] kx, ky, kz;
	logic [COORD_WIDTH-1:0] dx_q, dy_q, dz_q;
	logic [MUL_W-1:0]       op;
	logic [PROD_W-1:0]      sq;
	logic [PROD_W-1:0]      prod_q;
	logic [PROD_W-1:0]      tol2_q;
	logic [SUM_W-1:0]       acc_q;
	logic [SUM_W:0]         sum_raw;
	logic [SUM_W-1:0]       sum_sat;

	assign kx = kept[3*COORD_WIDTH-1:2*COORD_WIDTH];
	assign ky = kept[2*COORD_WIDTH-1:COORD_WIDTH];
	assign kz = kept[COORD_WIDTH-1:0];

	// the one shared squaring multiplier
	always_comb begin
		unique case (ctl.sel)
			SQ_TOL: op = MUL_W'(tolerance);
			SQ_DX:  op = MUL_W'(dx_q);
			SQ_DY:  op = MUL_W'(dy_q);
			SQ_DZ:  op = MUL_W'(dz_q);
			default: op = '0;
		endcase
	end
	assign sq = op * op;

	// saturating accumulate, then strict compare against tolerance squared
	assign sum_raw = {1'b0, acc_q} + {1'b0, SUM_W'(prod_q)};
	assign sum_sat = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
	assign hit     = sum_sat < SUM_W'(tol2_q);

	always_ff @(posedge clk) begin
		if (ctl.diff_en) begin
			dx_q <= abs_diff(px, kx);
			dy_q <= abs_diff(py, ky);
			dz_q <= abs_diff(pz, kz);
		end
		if (ctl.mul_en) begin
			prod_q <= sq;
		end
		if (ctl.tol_load) begin
			tol2_q <= prod_q;
		end
		if (ctl.acc_load) begin
			acc_q <= SUM_W'(prod_q);
		end else if (ctl.acc_add) begin
			acc_q <= sum_sat;
		end
	end
endmodule
